### sv/cbhr_pkg.sv
// Package for the cartridge bus handshake responder.
// Holds the phase type, the configuration bundle, register indexes, reset values and status codes.
// No dependencies.
package cbhr_pkg;

    // Configuration register indexes, in write-port order.
    localparam logic [2:0] REG_TRIGGER_A     = 3'd0;
    localparam logic [2:0] REG_RESPONSE_A    = 3'd1;
    localparam logic [2:0] REG_TRIGGER_B     = 3'd2;
    localparam logic [2:0] REG_RESPONSE_B    = 3'd3;
    localparam logic [2:0] REG_SETTLE_TICKS  = 3'd4;
    localparam logic [2:0] REG_HOLD_TICKS    = 3'd5;
    localparam logic [2:0] REG_RELEASE_TICKS = 3'd6;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_TRIGGER_A     = 8'h10;
    localparam logic [7:0] RST_RESPONSE_A    = 8'h01;
    localparam logic [7:0] RST_TRIGGER_B     = 8'h49;
    localparam logic [7:0] RST_RESPONSE_B    = 8'h07;
    localparam logic [9:0] RST_SETTLE_TICKS  = 10'd5;
    localparam logic [9:0] RST_HOLD_TICKS    = 10'd24;
    localparam logic [9:0] RST_RELEASE_TICKS = 10'd5;
    localparam logic [9:0] RST_TIMEOUT_TICKS = 10'd200;

    // Send status codes reported with each result.
    localparam logic [1:0] TX_NONE       = 2'd0;
    localparam logic [1:0] TX_SENT       = 2'd1;
    localparam logic [1:0] TX_NO_ACK     = 2'd2;
    localparam logic [1:0] TX_NO_RELEASE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RXACK   = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_WHIGH   = 3'd3,
        PH_RELEASE = 3'd4,
        PH_WLOW    = 3'd5,
        PH_HOLD    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] trigger_a;
        logic [7:0] response_a;
        logic [7:0] trigger_b;
        logic [7:0] response_b;
        logic [9:0] settle_ticks;
        logic [9:0] hold_ticks;
        logic [9:0] release_delay_ticks;
        logic [9:0] timeout_ticks;
    } cfg_t;

endpackage

### sv/cbhr_cfg_regs.sv
// Configuration register bank of the cartridge bus handshake responder.
// Depends on cbhr_pkg for register indexes, reset values and the cfg_t bundle.
module cbhr_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [cbhr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cbhr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cbhr_pkg::cfg_t                   cfg
);

    cbhr_pkg::cfg_t cfg_reg;
    cbhr_pkg::cfg_t cfg_next;

    // Decode a write into the addressed field.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                cbhr_pkg::REG_TRIGGER_A:     cfg_next.trigger_a = cfg_wdata[7:0];
                cbhr_pkg::REG_RESPONSE_A:    cfg_next.response_a = cfg_wdata[7:0];
                cbhr_pkg::REG_TRIGGER_B:     cfg_next.trigger_b = cfg_wdata[7:0];
                cbhr_pkg::REG_RESPONSE_B:    cfg_next.response_b = cfg_wdata[7:0];
                cbhr_pkg::REG_SETTLE_TICKS:  cfg_next.settle_ticks = cfg_wdata;
                cbhr_pkg::REG_HOLD_TICKS:    cfg_next.hold_ticks = cfg_wdata;
                cbhr_pkg::REG_RELEASE_TICKS: cfg_next.release_delay_ticks = cfg_wdata;
                cbhr_pkg::REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_a           <= cbhr_pkg::RST_TRIGGER_A;
            cfg_reg.response_a          <= cbhr_pkg::RST_RESPONSE_A;
            cfg_reg.trigger_b           <= cbhr_pkg::RST_TRIGGER_B;
            cfg_reg.response_b          <= cbhr_pkg::RST_RESPONSE_B;
            cfg_reg.settle_ticks        <= cbhr_pkg::RST_SETTLE_TICKS;
            cfg_reg.hold_ticks          <= cbhr_pkg::RST_HOLD_TICKS;
            cfg_reg.release_delay_ticks <= cbhr_pkg::RST_RELEASE_TICKS;
            cfg_reg.timeout_ticks       <= cbhr_pkg::RST_TIMEOUT_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/cartridge_bus_handshake_responder.sv
// Top level of the cartridge bus handshake responder.
// Depends on cbhr_pkg and instantiates cbhr_cfg_regs.
//
// Each input transaction is one sampled tick of the console strobe and data bus, and each
// produces exactly one result transaction with the line levels to drive for that tick.
// A tick is taken every clock cycle while the result register is empty or being taken: the
// handshake state machine updates its state and loads the result register in the same cycle.
// The result is registered and is offered in the cycle after its tick is accepted.
// Configuration writes are taken at any time but should be made while no tick is in flight.
module cartridge_bus_handshake_responder #(
    parameter int TIMER_BITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input ticks. s_tdata: [0] strobe_level, [8:1] bus_sample, [15:9] zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,
    // Results. m_tdata: [0] ack_line, [1] bus_enable, [9:2] bus_drive_value,
    // [10] rx_valid, [18:11] rx_byte, [20:19] tx_status, [23:21] zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [cbhr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cbhr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CMP_W = (TIMER_BITS > cbhr_pkg::CFG_DATA_W) ? TIMER_BITS
                                                               : cbhr_pkg::CFG_DATA_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    cbhr_pkg::cfg_t cfg;

    cbhr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake state.
    cbhr_pkg::phase_t        phase_reg, phase_next;
    logic                    prev_strobe_reg, prev_strobe_next;
    logic [TIMER_BITS-1:0]   wait_timer_reg, wait_timer_next;
    logic [TIMER_BITS-1:0]   drive_elapsed_reg, drive_elapsed_next;
    logic [7:0]              latched_rx_reg, latched_rx_next;
    logic [7:0]              pending_reg, pending_next;

    // Result register.
    logic                    m_valid_reg;
    logic [20:0]             m_data_reg;

    logic                    fire;
    logic                    strobe;
    logic [7:0]              bus;
    logic [TIMER_BITS-1:0]   wait_inc;
    logic [TIMER_BITS-1:0]   elapsed_inc;
    logic                    wait_timeout;
    logic                    wait_release;
    logic                    settle_done;
    logic                    hold_done;
    logic                    rx_done;
    logic                    match_a;
    logic                    match_b;
    logic                    ack;
    logic                    en;
    logic                    rxv;
    logic [1:0]              status;

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign strobe   = s_tdata[0];
    assign bus      = s_tdata[8:1];

    // Saturating timer increments and the threshold compares on the timers.
    assign wait_inc     = (wait_timer_reg == TMAX) ? TMAX : wait_timer_reg + 1'b1;
    assign elapsed_inc  = (drive_elapsed_reg == TMAX) ? TMAX : drive_elapsed_reg + 1'b1;
    assign wait_timeout = CMP_W'(wait_inc) >= CMP_W'(cfg.timeout_ticks);
    assign wait_release = CMP_W'(wait_inc) >= CMP_W'(cfg.release_delay_ticks);
    assign settle_done  = CMP_W'(drive_elapsed_reg) >= CMP_W'(cfg.settle_ticks);
    assign hold_done    = CMP_W'(drive_elapsed_reg) >= CMP_W'(cfg.hold_ticks);
    assign rx_done      = !strobe || wait_timeout;
    assign match_a      = latched_rx_reg == cfg.trigger_a;
    assign match_b      = latched_rx_reg == cfg.trigger_b;

    // Next-state logic for the handshake sequencer.
    always_comb begin
        phase_next         = phase_reg;
        prev_strobe_next   = prev_strobe_reg;
        wait_timer_next    = wait_timer_reg;
        drive_elapsed_next = drive_elapsed_reg;
        latched_rx_next    = latched_rx_reg;
        pending_next       = pending_reg;
        case (phase_reg)
            cbhr_pkg::PH_IDLE: begin
                if (strobe && !prev_strobe_reg) begin
                    latched_rx_next  = bus;
                    wait_timer_next  = '0;
                    prev_strobe_next = 1'b0;
                    phase_next       = cbhr_pkg::PH_RXACK;
                end else begin
                    prev_strobe_next = strobe;
                end
            end
            cbhr_pkg::PH_RXACK: begin
                if (strobe) begin
                    wait_timer_next = wait_inc;
                end
                if (rx_done) begin
                    prev_strobe_next = 1'b0;
                    phase_next       = cbhr_pkg::PH_IDLE;
                    if (match_a || match_b) begin
                        pending_next       = match_a ? cfg.response_a : cfg.response_b;
                        phase_next         = cbhr_pkg::PH_SETTLE;
                        drive_elapsed_next = TIMER_BITS'(1);
                    end
                end
            end
            cbhr_pkg::PH_SETTLE: begin
                if (settle_done) begin
                    wait_timer_next = '0;
                    phase_next      = cbhr_pkg::PH_WHIGH;
                end
                drive_elapsed_next = elapsed_inc;
            end
            cbhr_pkg::PH_WHIGH: begin
                if (strobe) begin
                    wait_timer_next    = '0;
                    phase_next         = (cfg.release_delay_ticks == '0) ? cbhr_pkg::PH_WLOW
                                                                         : cbhr_pkg::PH_RELEASE;
                    drive_elapsed_next = elapsed_inc;
                end else begin
                    wait_timer_next = wait_inc;
                    if (wait_timeout) begin
                        phase_next = cbhr_pkg::PH_IDLE;
                    end else begin
                        drive_elapsed_next = elapsed_inc;
                    end
                end
            end
            cbhr_pkg::PH_RELEASE: begin
                if (wait_release) begin
                    wait_timer_next = '0;
                    phase_next      = cbhr_pkg::PH_WLOW;
                end else begin
                    wait_timer_next = wait_inc;
                end
                drive_elapsed_next = elapsed_inc;
            end
            cbhr_pkg::PH_WLOW: begin
                if (!strobe) begin
                    if (hold_done) begin
                        phase_next = cbhr_pkg::PH_IDLE;
                    end else begin
                        phase_next         = cbhr_pkg::PH_HOLD;
                        drive_elapsed_next = elapsed_inc;
                    end
                end else begin
                    wait_timer_next = wait_inc;
                    if (wait_timeout) begin
                        phase_next = cbhr_pkg::PH_IDLE;
                    end else begin
                        drive_elapsed_next = elapsed_inc;
                    end
                end
            end
            cbhr_pkg::PH_HOLD: begin
                if (hold_done) begin
                    phase_next = cbhr_pkg::PH_IDLE;
                end else begin
                    drive_elapsed_next = elapsed_inc;
                end
            end
            default: begin
                phase_next       = cbhr_pkg::PH_IDLE;
                prev_strobe_next = strobe;
            end
        endcase
    end

    // Line levels and status for the current tick.
    always_comb begin
        ack    = 1'b0;
        en     = 1'b0;
        rxv    = 1'b0;
        status = cbhr_pkg::TX_NONE;
        case (phase_reg)
            cbhr_pkg::PH_IDLE: begin
                if (strobe && !prev_strobe_reg) begin
                    rxv = 1'b1;
                    ack = 1'b1;
                end
            end
            cbhr_pkg::PH_RXACK: begin
                ack = !rx_done;
                en  = rx_done && (match_a || match_b);
            end
            cbhr_pkg::PH_SETTLE: begin
                en  = 1'b1;
                ack = settle_done;
            end
            cbhr_pkg::PH_WHIGH: begin
                if (strobe) begin
                    ack = cfg.release_delay_ticks != '0;
                    en  = 1'b1;
                end else if (wait_timeout) begin
                    status = cbhr_pkg::TX_NO_ACK;
                end else begin
                    ack = 1'b1;
                    en  = 1'b1;
                end
            end
            cbhr_pkg::PH_RELEASE: begin
                ack = !wait_release;
                en  = 1'b1;
            end
            cbhr_pkg::PH_WLOW: begin
                if (!strobe) begin
                    if (hold_done) begin
                        status = cbhr_pkg::TX_SENT;
                    end else begin
                        en = 1'b1;
                    end
                end else if (wait_timeout) begin
                    status = cbhr_pkg::TX_NO_RELEASE;
                end else begin
                    en = 1'b1;
                end
            end
            cbhr_pkg::PH_HOLD: begin
                if (hold_done) begin
                    status = cbhr_pkg::TX_SENT;
                end else begin
                    en = 1'b1;
                end
            end
            default: begin
                ack = 1'b0;
            end
        endcase
    end

    // State update on each accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= cbhr_pkg::PH_IDLE;
            prev_strobe_reg   <= 1'b0;
            wait_timer_reg    <= '0;
            drive_elapsed_reg <= '0;
            latched_rx_reg    <= '0;
            pending_reg       <= '0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            prev_strobe_reg   <= prev_strobe_next;
            wait_timer_reg    <= wait_timer_next;
            drive_elapsed_reg <= drive_elapsed_next;
            latched_rx_reg    <= latched_rx_next;
            pending_reg       <= pending_next;
        end
    end

    // Result register: loaded on an accepted tick, emptied when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {status, latched_rx_next, rxv,
                           (en ? pending_next : 8'h00), en, ack};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};

endmodule
